// ===== sv/binary_region_perimeter_macros.svh =====
// assertion macros shared by the perimeter counter rtl
// expects i_clk and i_rst_n in the scope of each use
`ifndef BINARY_REGION_PERIMETER_MACROS_SVH
`define BINARY_REGION_PERIMETER_MACROS_SVH

// same-cycle implication, disabled in reset
`define BRP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("brp check failed");

// next-cycle implication, disabled in reset
`define BRP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("brp check failed");

`endif

// ===== sv/brp_pkg.sv =====
// shared types and constants for the binary region perimeter counter
// no dependencies
`timescale 1ns / 1ps

package brp_pkg;

    localparam int CFG_DIM_W  = 11;
    localparam int SCALE_W    = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int EDGE_W     = 23;
    localparam int FENCE_W    = 38;
    localparam int PROD_W     = EDGE_W + SCALE_W;

    localparam logic [EDGE_W-1:0]    EDGE_MAX  = {EDGE_W{1'b1}};
    localparam logic [FENCE_W-1:0]   FENCE_MAX = {FENCE_W{1'b1}};

    localparam logic [CFG_DIM_W-1:0] WIDTH_RESET  = 11'd1024;
    localparam logic [CFG_DIM_W-1:0] HEIGHT_RESET = 11'd1024;
    localparam logic [SCALE_W-1:0]   SCALE_RESET  = 16'd640;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAP_WIDTH    = 2'd0,
        CFG_MAP_HEIGHT   = 2'd1,
        CFG_LENGTH_SCALE = 2'd2
    } t_cfg_reg;

    // per-cell flags handed from the scan counters to the edge accumulator
    typedef struct packed {
        logic cur;
        logic left;
        logic row0;
        logic row_end;
        logic map_end;
    } t_cell_info;

endpackage

// ===== sv/brp_line_buf.sv =====
// one-row line buffer of land bits, synchronous read
// runs a zeroing sweep after reset; uses brp_pkg and the assertion macros
`timescale 1ns / 1ps
`include "binary_region_perimeter_macros.svh"

module brp_line_buf
    import brp_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int CW        = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic          i_wr_en,
    input  logic [CW-1:0] i_addr,
    input  logic          i_wr_data,
    output logic          o_rd_data,
    output logic          o_clearing
);

    logic          r_mem [MAX_WIDTH];
    logic          r_rd_data;
    logic          r_clearing;
    logic [CW-1:0] r_clr_addr;
    logic          n_clearing;
    logic [CW-1:0] n_clr_addr;
    logic          wr_go;
    logic [CW-1:0] wr_addr;
    logic          wr_bit;

    always_comb begin
        n_clearing = r_clearing;
        n_clr_addr = r_clr_addr;
        if (r_clearing) begin
            n_clr_addr = r_clr_addr + CW'(1);
            if (r_clr_addr == CW'(MAX_WIDTH - 1)) begin
                n_clearing = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_clearing <= n_clearing;
            r_clr_addr <= n_clr_addr;
        end
    end

    assign wr_go   = r_clearing || i_wr_en;
    assign wr_addr = r_clearing ? r_clr_addr : i_addr;
    assign wr_bit  = r_clearing ? 1'b0 : i_wr_data;

    // read-before-write on the same entry returns the previous row's bit
    always_ff @(posedge i_clk) begin
        if (wr_go) begin
            r_mem[wr_addr] <= wr_bit;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clearing;

    `BRP_ASSERT_NOW(a_no_access_in_clear, r_clearing, !i_wr_en && !i_rd_en)
    `BRP_ASSERT_NEXT(a_clear_ends, r_clearing && (r_clr_addr == CW'(MAX_WIDTH - 1)),
        !r_clearing)
    `BRP_ASSERT_NEXT(a_clear_stays_done, !r_clearing, !r_clearing)

endmodule

// ===== sv/brp_scan_ctrl.sv =====
// raster position counters, left neighbour and row land count
// loads the stage register feeding the edge accumulator; uses brp_pkg
`timescale 1ns / 1ps
`include "binary_region_perimeter_macros.svh"

module brp_scan_ctrl
    import brp_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int CW         = 10,
    parameter int RW         = 10,
    parameter int LW         = 11
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic                 i_cell,
    input  logic [CFG_DIM_W-1:0] i_map_width,
    input  logic [CFG_DIM_W-1:0] i_map_height,
    input  logic                 i_s1_take,
    output logic [CW-1:0]        o_addr,
    output logic                 o_s1_valid,
    output t_cell_info           o_s1_info,
    output logic [LW-1:0]        o_s1_land_cnt
);

    localparam int WCW = ($clog2(MAX_WIDTH + 1) > CFG_DIM_W) ?
                         $clog2(MAX_WIDTH + 1) : CFG_DIM_W;
    localparam int HCW = ($clog2(MAX_HEIGHT + 1) > CFG_DIM_W) ?
                         $clog2(MAX_HEIGHT + 1) : CFG_DIM_W;

    logic [CW-1:0]  r_col;
    logic [RW-1:0]  r_row;
    logic           r_left;
    logic [LW-1:0]  r_cnt;
    logic           r_s1_valid;
    t_cell_info     r_s1_info;
    logic [LW-1:0]  r_s1_land_cnt;

    logic [CW-1:0]  n_col;
    logic [RW-1:0]  n_row;
    logic           n_left;
    logic [LW-1:0]  n_cnt;
    t_cell_info     n_info;
    logic [LW-1:0]  cnt_incl;

    logic [WCW-1:0] w_ext;
    logic [WCW-1:0] w_eff;
    logic [WCW-1:0] col_p1;
    logic [HCW-1:0] h_ext;
    logic [HCW-1:0] h_eff;
    logic [HCW-1:0] row_p1;

    always_comb begin
        // zero acts as one, oversize acts as the maximum
        w_ext = WCW'(i_map_width);
        if (w_ext == '0) begin
            w_eff = WCW'(1);
        end else if (w_ext > WCW'(MAX_WIDTH)) begin
            w_eff = WCW'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        h_ext = HCW'(i_map_height);
        if (h_ext == '0) begin
            h_eff = HCW'(1);
        end else if (h_ext > HCW'(MAX_HEIGHT)) begin
            h_eff = HCW'(MAX_HEIGHT);
        end else begin
            h_eff = h_ext;
        end
        col_p1 = WCW'(r_col) + WCW'(1);
        row_p1 = HCW'(r_row) + HCW'(1);

        cnt_incl       = r_cnt + LW'(i_cell);
        n_info.cur     = i_cell;
        n_info.left    = (r_col == '0) ? 1'b0 : r_left;
        n_info.row0    = (r_row == '0);
        n_info.row_end = (col_p1 >= w_eff);
        n_info.map_end = n_info.row_end && (row_p1 >= h_eff);

        n_left = i_cell;
        n_cnt  = cnt_incl;
        n_col  = r_col + CW'(1);
        n_row  = r_row;
        if (n_info.row_end) begin
            n_left = 1'b0;
            n_cnt  = '0;
            n_col  = '0;
            n_row  = n_info.map_end ? '0 : r_row + RW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_left     <= 1'b0;
            r_cnt      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_col      <= n_col;
                r_row      <= n_row;
                r_left     <= n_left;
                r_cnt      <= n_cnt;
                r_s1_valid <= 1'b1;
            end else if (i_s1_take) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_info     <= n_info;
            r_s1_land_cnt <= cnt_incl;
        end
    end

    assign o_addr        = r_col;
    assign o_s1_valid    = r_s1_valid;
    assign o_s1_info     = r_s1_info;
    assign o_s1_land_cnt = r_s1_land_cnt;

    `BRP_ASSERT_NEXT(a_row_end_wraps, i_accept && n_info.row_end,
        (r_col == '0) && !r_left && (r_cnt == '0))
    `BRP_ASSERT_NEXT(a_map_end_restarts, i_accept && n_info.map_end, r_row == '0)

endmodule

// ===== sv/brp_edge_acc.sv =====
// edge accumulator: adds the boundary sides of each cell to the map total
// holds the finished total until the scaler takes it; uses brp_pkg
`timescale 1ns / 1ps
`include "binary_region_perimeter_macros.svh"

module brp_edge_acc
    import brp_pkg::*;
#(
    parameter int LW = 11
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s1_valid,
    input  t_cell_info        i_s1_info,
    input  logic [LW-1:0]     i_s1_land_cnt,
    input  logic              i_above,
    input  logic              i_res_ready,
    output logic              o_s1_take,
    output logic              o_res_valid,
    output logic [EDGE_W-1:0] o_res_edge
);

    localparam int SUMW = ((LW > EDGE_W) ? LW : EDGE_W) + 2;

    logic [EDGE_W-1:0] r_edge;
    logic              r_res_valid;
    logic [EDGE_W-1:0] r_res_edge;
    logic              above_eff;
    logic [SUMW-1:0]   sum;
    logic [EDGE_W-1:0] n_edge;
    logic              res_free;
    logic              take;

    always_comb begin
        above_eff = i_s1_info.row0 ? 1'b0 : i_above;
        sum = SUMW'(r_edge)
            + SUMW'(i_s1_info.cur ^ i_s1_info.left)
            + SUMW'(i_s1_info.cur ^ above_eff)
            + SUMW'(i_s1_info.cur & i_s1_info.row_end)
            + (i_s1_info.map_end ? SUMW'(i_s1_land_cnt) : SUMW'(0));
        // saturating total
        n_edge = (sum > SUMW'(EDGE_MAX)) ? EDGE_MAX : sum[EDGE_W-1:0];
    end

    assign res_free = !r_res_valid || i_res_ready;
    assign take     = i_s1_valid && (!i_s1_info.map_end || res_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
            if (take) begin
                if (i_s1_info.map_end) begin
                    r_edge      <= '0;
                    r_res_valid <= 1'b1;
                end else begin
                    r_edge <= n_edge;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_s1_info.map_end) begin
            r_res_edge <= n_edge;
        end
    end

    assign o_s1_take   = take;
    assign o_res_valid = r_res_valid;
    assign o_res_edge  = r_res_edge;

    `BRP_ASSERT_NEXT(a_result_held, r_res_valid && !i_res_ready,
        r_res_valid && $stable(r_res_edge))
    `BRP_ASSERT_NOW(a_no_overwrite, r_res_valid && !i_res_ready,
        !(take && i_s1_info.map_end))

endmodule

// ===== sv/brp_out_scale.sv =====
// output stage: scales the finished edge count by the Q8.8 side length
// registered product with saturation; uses brp_pkg
`timescale 1ns / 1ps

module brp_out_scale
    import brp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_res_valid,
    input  logic [EDGE_W-1:0]  i_res_edge,
    input  logic [SCALE_W-1:0] i_scale,
    input  logic               i_ready,
    output logic               o_res_ready,
    output logic               o_valid,
    output logic [EDGE_W-1:0]  o_edge_count,
    output logic [FENCE_W-1:0] o_fence_length
);

    logic               r_valid;
    logic [EDGE_W-1:0]  r_edge;
    logic [FENCE_W-1:0] r_fence;
    logic [PROD_W-1:0]  prod;
    logic [FENCE_W-1:0] n_fence;
    logic               load;

    always_comb begin
        prod    = PROD_W'(i_res_edge) * PROD_W'(i_scale);
        n_fence = (prod > PROD_W'(FENCE_MAX)) ? FENCE_MAX : prod[FENCE_W-1:0];
    end

    assign o_res_ready = !r_valid || i_ready;
    assign load        = i_res_valid && o_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_res_ready) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_edge  <= i_res_edge;
            r_fence <= n_fence;
        end
    end

    assign o_valid        = r_valid;
    assign o_edge_count   = r_edge;
    assign o_fence_length = r_fence;

endmodule

// ===== sv/binary_region_perimeter.sv =====
// Binary region perimeter counter. Takes one map cell per cycle in raster order and, after
// the last cell of a map_width x map_height map, returns the count of land-cell sides that
// face water or the border, together with that count times the Q8.8 length_scale. The
// sustained rate is one cell per clock; past the reset clear, input is held off only while
// a result cannot move toward a stalled output. The only per-cell state in memory is the
// previous row's land bit, read from and written back to the single-port line buffer in
// the cycle of acceptance. A result passes the stage, accumulator result and output
// registers. After reset the line buffer is zeroed, one entry a cycle, over its MAX_WIDTH
// entries, during which no cell is accepted; configuration writes are taken at any time.
// depends on brp_pkg, brp_line_buf, brp_scan_ctrl, brp_edge_acc, brp_out_scale
`timescale 1ns / 1ps

module binary_region_perimeter
    import brp_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_cell_is_land,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [EDGE_W-1:0]     o_edge_count,
    output logic [FENCE_W-1:0]    o_fence_length,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int LW = $clog2(MAX_WIDTH + 1);

    logic [CFG_DIM_W-1:0] r_map_width;
    logic [CFG_DIM_W-1:0] r_map_height;
    logic [SCALE_W-1:0]   r_length_scale;

    logic              accept;
    logic              clearing;
    logic              above;
    logic [CW-1:0]     addr;
    logic              s1_valid;
    t_cell_info        s1_info;
    logic [LW-1:0]     s1_land_cnt;
    logic              s1_take;
    logic              res_valid;
    logic              res_ready;
    logic [EDGE_W-1:0] res_edge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width    <= WIDTH_RESET;
            r_map_height   <= HEIGHT_RESET;
            r_length_scale <= SCALE_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                CFG_MAP_WIDTH:    r_map_width    <= i_cfg_data[CFG_DIM_W-1:0];
                CFG_MAP_HEIGHT:   r_map_height   <= i_cfg_data[CFG_DIM_W-1:0];
                CFG_LENGTH_SCALE: r_length_scale <= i_cfg_data[SCALE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // a new request enters only when the stage holding the last one moves on
    assign o_ready = !clearing && (!s1_valid || s1_take);
    assign accept  = i_valid && o_ready;

    brp_line_buf #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW)
    ) u_line_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (accept),
        .i_wr_en    (accept),
        .i_addr     (addr),
        .i_wr_data  (i_cell_is_land),
        .o_rd_data  (above),
        .o_clearing (clearing)
    );

    brp_scan_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CW         (CW),
        .RW         (RW),
        .LW         (LW)
    ) u_scan_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_cell        (i_cell_is_land),
        .i_map_width   (r_map_width),
        .i_map_height  (r_map_height),
        .i_s1_take     (s1_take),
        .o_addr        (addr),
        .o_s1_valid    (s1_valid),
        .o_s1_info     (s1_info),
        .o_s1_land_cnt (s1_land_cnt)
    );

    brp_edge_acc #(
        .LW (LW)
    ) u_edge_acc (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s1_valid    (s1_valid),
        .i_s1_info     (s1_info),
        .i_s1_land_cnt (s1_land_cnt),
        .i_above       (above),
        .i_res_ready   (res_ready),
        .o_s1_take     (s1_take),
        .o_res_valid   (res_valid),
        .o_res_edge    (res_edge)
    );

    brp_out_scale u_out_scale (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_res_valid    (res_valid),
        .i_res_edge     (res_edge),
        .i_scale        (r_length_scale),
        .i_ready        (i_ready),
        .o_res_ready    (res_ready),
        .o_valid        (o_valid),
        .o_edge_count   (o_edge_count),
        .o_fence_length (o_fence_length)
    );

endmodule

// ===== dv/tb_binary_region_perimeter.sv =====
// self-checking testbench for the binary region perimeter counter
// depends on brp_pkg and the binary_region_perimeter rtl; reads and writes no files
`timescale 1ns / 1ps

module tb_binary_region_perimeter;
    import brp_pkg::*;

    localparam int MAX_W          = 1024;
    localparam int MAX_H          = 1024;
    localparam int RANDOM_CELLS   = 450;
    localparam int DRAIN_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 6000;

    // index with no register behind it, writes must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    typedef struct {
        logic [EDGE_W-1:0]  edges;
        logic [FENCE_W-1:0] fence;
    } t_perimeter;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic                  i_cell_is_land;
    logic                  o_valid;
    logic                  i_ready;
    logic [EDGE_W-1:0]     o_edge_count;
    logic [FENCE_W-1:0]    o_fence_length;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // mirror of the configuration registers
    logic [CFG_DIM_W-1:0]  cfg_width  = WIDTH_RESET;
    logic [CFG_DIM_W-1:0]  cfg_height = HEIGHT_RESET;
    logic [SCALE_W-1:0]    cfg_scale  = SCALE_RESET;

    // scan state of the perimeter predictor
    bit                    line_above [MAX_W];
    bit                    prev_land;
    int unsigned           scan_col;
    int unsigned           scan_row;
    int unsigned           row_land;
    logic [EDGE_W-1:0]     side_total;

    t_perimeter            expected_perimeters [$];

    bit                    steady;
    int unsigned           fail_count;
    int unsigned           cells_sent;
    int unsigned           maps_checked;
    int unsigned           quiet_cycles;

    binary_region_perimeter #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cell_is_land (i_cell_is_land),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_edge_count   (o_edge_count),
        .o_fence_length (o_fence_length),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic void add_sides(int unsigned n);
        if (n > EDGE_MAX - side_total) side_total = EDGE_MAX;
        else side_total = EDGE_W'(side_total + n);
    endfunction

    function automatic void restart_scan();
        prev_land  = 1'b0;
        scan_col   = 0;
        scan_row   = 0;
        row_land   = 0;
        side_total = '0;
    endfunction

    // one accepted cell: update the scan state, queue a perimeter at the map end
    function automatic void count_cell_sides(input bit land);
        int unsigned       w;
        int unsigned       h;
        int unsigned       col;
        bit                lft;
        bit                abv;
        bit                row_end;
        bit                map_end;
        logic [PROD_W-1:0] prod;
        t_perimeter        res;
        w = (cfg_width == 0) ? 1 : ((cfg_width > MAX_W) ? MAX_W : cfg_width);
        h = (cfg_height == 0) ? 1 : ((cfg_height > MAX_H) ? MAX_H : cfg_height);
        col = (scan_col >= MAX_W) ? MAX_W - 1 : scan_col;
        lft = (scan_col == 0) ? 1'b0 : prev_land;
        abv = (scan_row == 0) ? 1'b0 : line_above[col];
        if (land != lft) add_sides(1);
        if (land != abv) add_sides(1);
        if (land) row_land++;
        line_above[col] = land;
        prev_land = land;
        row_end = (scan_col + 1 >= w);
        map_end = row_end && (scan_row + 1 >= h);
        if (!row_end) begin
            scan_col++;
            return;
        end
        if (land) add_sides(1);
        if (map_end) add_sides(row_land);
        scan_col  = 0;
        row_land  = 0;
        prev_land = 1'b0;
        if (!map_end) begin
            scan_row++;
            return;
        end
        prod = PROD_W'(side_total) * PROD_W'(cfg_scale);
        res.edges = side_total;
        res.fence = (prod > PROD_W'(FENCE_MAX)) ? FENCE_MAX : prod[FENCE_W-1:0];
        expected_perimeters.insert(expected_perimeters.size(), res);
        restart_scan();
    endfunction

    function automatic bit pick_land(int unsigned pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // leaves valid high so a following request can go out in the next cycle
    task automatic send_cell(input bit land);
        if (!steady && $urandom_range(0, 99) < 25) begin
            i_valid        <= 1'b0;
            i_cell_is_land <= 1'($urandom_range(0, 1));
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_cell_is_land <= land;
        do @(posedge i_clk); while (!o_ready);
        cells_sent++;
        count_cell_sides(land);
    endtask

    task automatic finish_map(input int unsigned pct);
        while (scan_col != 0 || scan_row != 0) send_cell(pick_land(pct));
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (expected_perimeters.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // write enable stays high across back-to-back writes, end_writes lowers it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_MAP_WIDTH:    cfg_width  = data[CFG_DIM_W-1:0];
            CFG_MAP_HEIGHT:   cfg_height = data[CFG_DIM_W-1:0];
            CFG_LENGTH_SCALE: cfg_scale  = data[SCALE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        i_cfg_we   <= 1'b0;
        i_cfg_data <= CFG_DATA_W'($urandom);
    endtask

    task automatic reconfigure(input int unsigned w, input int unsigned h,
                               input logic [SCALE_W-1:0] scale);
        drain_results();
        // junk above the size field must be dropped
        write_reg(CFG_MAP_WIDTH, {5'($urandom), CFG_DIM_W'(w)});
        write_reg(CFG_MAP_HEIGHT, {5'($urandom), CFG_DIM_W'(h)});
        write_reg(CFG_LENGTH_SCALE, scale);
        end_writes();
    endtask

    task automatic test_reset_scale();
        drain_results();
        write_reg(CFG_MAP_WIDTH, 16'd3);
        write_reg(CFG_MAP_HEIGHT, 16'd2);
        end_writes();
        repeat (6) send_cell(1'b1);
    endtask

    task automatic test_degenerate_sizes();
        reconfigure(0, 0, 16'hFFFF);
        send_cell(1'b1);
        send_cell(1'b0);
        drain_results();
        write_reg(CFG_LENGTH_SCALE, 16'h0000);
        write_reg(CFG_SPARE_IDX, 16'hFFFF);
        end_writes();
        send_cell(1'b1);
    endtask

    task automatic test_checkerboard();
        reconfigure(3, 3, 16'd256);
        for (int i = 0; i < 9; i++) send_cell(i[0]);
    endtask

    task automatic test_midmap_resize();
        reconfigure(5, 3, 16'd640);
        repeat (3) send_cell(1'b1);
        // column already past the new width, row closes on the next cell
        drain_results();
        write_reg(CFG_MAP_WIDTH, 16'hF802);
        end_writes();
        repeat (3) send_cell(1'b1);
        // shrinking the height below the current row ends the map at this row
        drain_results();
        write_reg(CFG_MAP_HEIGHT, 16'd1);
        end_writes();
        finish_map(50);
    endtask

    task automatic test_random_maps();
        int unsigned start;
        int unsigned map_no;
        int unsigned w;
        int unsigned h;
        int unsigned pct;
        logic [SCALE_W-1:0] scale;
        bit resized;
        start  = cells_sent;
        map_no = 0;
        while (cells_sent - start < RANDOM_CELLS) begin
            map_no++;
            steady = (map_no >= 12 && map_no < 20);
            if (map_no == 1 || $urandom_range(0, 2) == 0) begin
                w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
                h = $urandom_range(1, 6);
                case ($urandom_range(0, 3))
                    0:       scale = '0;
                    1:       scale = '1;
                    default: scale = SCALE_W'($urandom);
                endcase
                reconfigure(w, h, scale);
            end
            case ($urandom_range(0, 4))
                0:       pct = 0;
                1:       pct = 100;
                default: pct = $urandom_range(10, 90);
            endcase
            resized = 1'b0;
            send_cell(pick_land(pct));
            while (scan_col != 0 || scan_row != 0) begin
                if (!resized && $urandom_range(0, 15) == 0) begin
                    drain_results();
                    if ($urandom_range(0, 1)) begin
                        write_reg(CFG_MAP_WIDTH, CFG_DATA_W'($urandom_range(0, 8)));
                    end else begin
                        write_reg(CFG_MAP_HEIGHT, CFG_DATA_W'($urandom_range(0, 6)));
                    end
                    end_writes();
                    resized = 1'b1;
                end
                send_cell(pick_land(pct));
            end
        end
        steady = 1'b0;
    endtask

    task automatic test_largest_maps();
        // oversize width acts as the maximum, so twenty cells never close the row
        reconfigure(2047, 3, 16'hFFFF);
        repeat (20) send_cell(pick_land(60));
        drain_results();
        write_reg(CFG_MAP_WIDTH, 16'd8);
        end_writes();
        finish_map(60);
        // oversize height acts as the maximum, a zero height then closes the map
        reconfigure(2, 2047, SCALE_W'($urandom));
        repeat (30) send_cell(pick_land(60));
        drain_results();
        write_reg(CFG_MAP_HEIGHT, 16'd0);
        end_writes();
        finish_map(60);
    endtask

    // result side: check each accepted result, then stall at random
    always @(posedge i_clk) begin
        t_perimeter want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_perimeters.size() == 0) begin
                $display("%0t ns: result with no request pending, edge_count %0d fence_length %0d",
                         $time, o_edge_count, o_fence_length);
                fail_count++;
            end else begin
                want = expected_perimeters.pop_front();
                maps_checked++;
                if (o_edge_count !== want.edges) begin
                    $display("%0t ns: edge_count expected %0d actual %0d",
                             $time, want.edges, o_edge_count);
                    fail_count++;
                end
                if (o_fence_length !== want.fence) begin
                    $display("%0t ns: fence_length expected %0d actual %0d",
                             $time, want.fence, o_fence_length);
                    fail_count++;
                end
            end
        end
        if (i_rst_n) i_ready <= steady || ($urandom_range(0, 99) >= 25);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no request moved for %0d cycles", $time, quiet_cycles);
            $display("tb_binary_region_perimeter: errors");
            $finish;
        end
    end

    initial begin
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_cell_is_land <= 1'b0;
        i_ready        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= CFG_MAP_WIDTH;
        i_cfg_data     <= '0;
        steady         = 1'b0;
        fail_count     = 0;
        cells_sent     = 0;
        maps_checked   = 0;
        quiet_cycles   = 0;
        for (int i = 0; i < MAX_W; i++) line_above[i] = 1'b0;
        restart_scan();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_scale();
        test_degenerate_sizes();
        test_checkerboard();
        test_midmap_resize();
        test_random_maps();
        test_largest_maps();
        drain_results();

        $display("covered %0d cells and %0d maps: clamped sizes, mid-map resizes, scales 0..65535",
                 cells_sent, maps_checked);
        $display("oversize widths and heights held at the 1024 maximum, random stalls on both sides");
        if (fail_count == 0) begin
            $display("tb_binary_region_perimeter: clean");
        end else begin
            $display("tb_binary_region_perimeter: errors");
        end
        $finish;
    end

endmodule
